FILE: hdl/sensor_uart_frame_parser_assert.svh
// Assertion helpers used by the frame parser core RTL.
`ifndef SENSOR_UART_FRAME_PARSER_ASSERT_SVH
`define SENSOR_UART_FRAME_PARSER_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define SUFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define SUFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sufp_pkg.sv
`timescale 1ns / 1ps
package sufp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReadingW = 16;
  localparam int unsigned IdxW     = 4;

  // Frame layout: sync, type, six body bytes, checksum.
  localparam logic [IdxW-1:0] FrameLen  = 4'd9;
  localparam logic [IdxW-1:0] FirstBody = 4'd2;
  localparam logic [IdxW-1:0] IdxHigh   = 4'd4;
  localparam logic [IdxW-1:0] IdxLow    = 4'd5;
  localparam logic [IdxW-1:0] IdxCsum   = 4'd8;
  localparam logic [IdxW-1:0] IdxHunt   = 4'd0;

  localparam logic [ByteW-1:0] SyncReset = 8'hFF;
  localparam logic [ByteW-1:0] TypeReset = 8'h18;

  // Configuration register indexes.
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_TYPE = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                err;
    logic [ReadingW-1:0] reading;
  } frame_res_t;

endpackage

FILE: hdl/sufp_core.sv
`timescale 1ns / 1ps
module sufp_core import sufp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] sync_byte_i,
  input  logic [ByteW-1:0] type_byte_i,
  output frame_res_t       res_o
);

  logic             sync_seen_q, sync_seen_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] hi_q, hi_d;
  logic [ByteW-1:0] lo_q, lo_d;
  logic             hunting;
  logic [ByteW-1:0] csum_total;

  assign hunting    = (idx_q < FirstBody) || (idx_q >= FrameLen);
  // Frame is good when the type and body sum plus checksum wraps to zero.
  assign csum_total = sum_q + byte_i;

  always_comb begin
    sync_seen_d   = sync_seen_q;
    idx_d         = idx_q;
    sum_d         = sum_q;
    hi_d          = hi_q;
    lo_d          = lo_q;
    res_o.valid   = 1'b0;
    res_o.err     = 1'b0;
    res_o.reading = {hi_q, lo_q};
    if (byte_valid_i) begin
      if (hunting) begin
        // Type test goes first so a sync equal to type still completes the header.
        if (sync_seen_q && (byte_i == type_byte_i)) begin
          sync_seen_d = 1'b0;
          sum_d       = byte_i;
          idx_d       = FirstBody;
        end else begin
          idx_d       = IdxHunt;
          sync_seen_d = (byte_i == sync_byte_i);
        end
      end else if (idx_q == IdxCsum) begin
        res_o.valid = 1'b1;
        res_o.err   = (csum_total != '0);
        sync_seen_d = 1'b0;
        idx_d       = IdxHunt;
        sum_d       = '0;
      end else begin
        sum_d = csum_total;
        if (idx_q == IdxHigh) hi_d = byte_i;
        if (idx_q == IdxLow)  lo_d = byte_i;
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_seen_q <= 1'b0;
      idx_q       <= IdxHunt;
      sum_q       <= '0;
    end else begin
      sync_seen_q <= sync_seen_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

`include "sensor_uart_frame_parser_assert.svh"

  `SUFP_ASSERT(a_idx_legal, clk_i, rst_ni, (idx_q == IdxHunt) || ((idx_q >= FirstBody) && (idx_q <= IdxCsum)), "byte index out of range")
  `SUFP_ASSERT(a_sync_only_hunting, clk_i, rst_ni, sync_seen_q |-> (idx_q == IdxHunt), "sync armed outside hunt")
  `SUFP_ASSERT(a_res_at_csum, clk_i, rst_ni, res_o.valid |-> (idx_q == IdxCsum), "result away from checksum byte")
  `SUFP_ASSERT(a_hunt_after_res, clk_i, rst_ni, res_o.valid |=> ((idx_q == IdxHunt) && !sync_seen_q), "no return to hunt")

endmodule

FILE: hdl/sensor_uart_frame_parser.sv
`timescale 1ns / 1ps
// Sensor UART frame parser.
// Input stream: one received byte per word on s_axis (tdata[7:0]).
// Output stream: one word per nine-byte frame on m_axis; tdata holds the
// big-endian reading from frame bytes 4 and 5, tuser is the status flag
// (0 good frame, 1 checksum error, reading forced to zero).
// Configuration: cfg_we_i writes register cfg_idx_i (0 sync byte, 1 type
// byte) with cfg_wdata_i; write only while no frame is in progress.
// Throughput: one byte per cycle while s_axis_tready_o is high. Each byte is
// handled by a single level of compare and 8-bit add logic between the
// parser state and the result register.
// Latency: the result word shows on m_axis the cycle after the checksum byte
// is accepted.
// Reset: hunt state, sync/type registers (0xFF / 0x18) and output valid are
// cleared at once; no clearing pass.
// Stall: the result register holds while m_axis_tready_i is low; input bytes
// are taken while that register is empty or being drained.
module sensor_uart_frame_parser import sufp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ReadingW-1:0] m_axis_tdata_o,   // [15:0] reading
  output logic                m_axis_tuser_o,   // [0] status
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [ByteW-1:0]    cfg_wdata_i
);

  logic [ByteW-1:0]    sync_q, sync_d;
  logic [ByteW-1:0]    type_q, type_d;
  logic                out_valid_q, out_valid_d;
  logic                err_q, err_d;
  logic [ReadingW-1:0] last_good_q, last_good_d;
  logic                in_fire;
  frame_res_t          res;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  sufp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .byte_i       (s_axis_tdata_i),
    .sync_byte_i  (sync_q),
    .type_byte_i  (type_q),
    .res_o        (res)
  );

  always_comb begin
    sync_d = sync_q;
    type_d = type_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC: sync_d = cfg_wdata_i;
        REG_TYPE: type_d = cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    err_d       = err_q;
    last_good_d = last_good_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (res.valid) begin
      out_valid_d = 1'b1;
      err_d       = res.err;
      // Keep the last good reading; drive it out on good frames.
      if (!res.err) last_good_d = res.reading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= SyncReset;
      type_q      <= TypeReset;
      out_valid_q <= 1'b0;
      last_good_q <= '0;
    end else begin
      sync_q      <= sync_d;
      type_q      <= type_d;
      out_valid_q <= out_valid_d;
      last_good_q <= last_good_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = err_q;
  assign m_axis_tdata_o  = err_q ? '0 : last_good_q;

endmodule

FILE: dv/sufp_frame_checker.sv
`timescale 1ns / 1ps
module sufp_frame_checker import sufp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [ReadingW-1:0] m_axis_tdata_i,   // [15:0] reading
  input  logic                m_axis_tuser_i,   // [0] status
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [ByteW-1:0]    cfg_wdata_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output logic                hunt_idle_o
);

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusCsumErr = 1'b1;

  typedef struct packed {
    logic [ReadingW-1:0] reading;
    logic                status;
  } frame_reading_t;

  frame_reading_t readings_due[$];

  logic [ByteW-1:0]    sync_val;
  logic [ByteW-1:0]    type_val;
  logic                armed;
  logic [IdxW-1:0]     pos;
  logic [ByteW-1:0]    frame_sum;
  logic [ByteW-1:0]    value_hi;
  logic [ByteW-1:0]    value_lo;
  logic [ReadingW-1:0] last_good;

  always @(posedge clk_i or negedge rst_ni) begin
    frame_reading_t want;
    logic [ByteW-1:0] rx;
    logic [ByteW-1:0] neg_sum;
    if (!rst_ni) begin
      readings_due.delete();
      sync_val   = SyncReset;
      type_val   = TypeReset;
      armed      = 1'b0;
      pos        = IdxHunt;
      frame_sum  = '0;
      value_hi   = '0;
      value_lo   = '0;
      last_good  = '0;
      fail_cnt_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got reading %h status %b",
                   $time, m_axis_tdata_i, m_axis_tuser_i);
          fail_cnt_o++;
        end else begin
          want = readings_due.pop_front();
          if (m_axis_tdata_i !== want.reading || m_axis_tuser_i !== want.status) begin
            $display("%0t: mismatch, expected reading %h status %b, got reading %h status %b",
                     $time, want.reading, want.status, m_axis_tdata_i, m_axis_tuser_i);
            fail_cnt_o++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        rx = s_axis_tdata_i;
        if (pos < FirstBody || pos >= FrameLen) begin
          // type check comes first, so a sync equal to type completes the header
          if (armed && rx == type_val) begin
            armed     = 1'b0;
            frame_sum = rx;
            pos       = FirstBody;
          end else begin
            pos   = IdxHunt;
            armed = (rx == sync_val);
          end
        end else if (pos == IdxCsum) begin
          neg_sum = ~frame_sum + 8'd1;
          if (rx == neg_sum) begin
            last_good = {value_hi, value_lo};
            readings_due.push_back('{reading: last_good, status: StatusOk});
          end else begin
            readings_due.push_back('{reading: '0, status: StatusCsumErr});
          end
          armed     = 1'b0;
          pos       = IdxHunt;
          frame_sum = '0;
        end else begin
          frame_sum = frame_sum + rx;
          if (pos == IdxHigh) begin
            value_hi = rx;
          end else if (pos == IdxLow) begin
            value_lo = rx;
          end
          pos = pos + 1'b1;
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SYNC: sync_val = cfg_wdata_i;
          REG_TYPE: type_val = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o   = readings_due.size();
    hunt_idle_o = !armed && (pos < FirstBody || pos >= FrameLen);
  end

endmodule

FILE: dv/tb_sensor_uart_frame_parser.sv
`timescale 1ns / 1ps
module tb_sensor_uart_frame_parser;
  import sufp_pkg::*;

  localparam int QuietLimit  = 3000;
  localparam int HoldCycles  = 400;
  localparam int PhaseBytes  = 300;
  localparam int NumPhases   = 5;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b1;
  logic [ReadingW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = REG_SYNC;
  logic [ByteW-1:0]    cfg_wdata = '0;

  int                  fail_cnt;
  int                  pending;
  logic                hunt_idle;

  logic [ByteW-1:0]    sync_cfg = SyncReset;
  logic [ByteW-1:0]    type_cfg = TypeReset;
  bit                  send_idle = 1'b0;
  bit                  recv_stall = 1'b0;
  bit                  hold_req = 1'b0;
  int                  idle_pct = 68;
  int                  bytes_sent = 0;
  int                  quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  sensor_uart_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  sufp_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .hunt_idle_o    (hunt_idle)
  );

  // Entered and left at a falling edge; tvalid stays high for back-to-back words.
  task automatic push_byte(input logic [ByteW-1:0] rx);
    while (send_idle && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rx;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // body holds frame bytes 2..7, byte 2 in the lowest bits
  task automatic send_frame(input logic [47:0] body, input bit corrupt);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] csum;
    sum = type_cfg;
    for (int i = 0; i < 6; i++) sum = sum + body[8*i +: 8];
    csum = 8'd0 - sum;
    if (corrupt) csum = csum + 8'($urandom_range(255, 1));
    push_byte(sync_cfg);
    push_byte(type_cfg);
    for (int i = 0; i < 6; i++) push_byte(body[8*i +: 8]);
    push_byte(csum);
  endtask

  // Finish any open frame, drop the armed sync, then drain all results.
  task automatic settle();
    logic [ByteW-1:0] filler;
    filler = 8'h00;
    while (filler == sync_cfg || filler == type_cfg) filler++;
    while (!hunt_idle) push_byte(filler);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [ByteW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
  endtask

  task automatic random_traffic();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(48'({$urandom(), $urandom()}), $urandom_range(3) == 0);
      end else if (pick < 78) begin
        push_byte(8'($urandom_range(255)));
      end else if (pick < 86) begin
        // sync followed by anything
        push_byte(sync_cfg);
        push_byte(8'($urandom_range(255)));
      end else if (pick < 92) begin
        // truncated frame: the next words land in its body
        push_byte(sync_cfg);
        push_byte(type_cfg);
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(3, 1)) push_byte(sync_cfg);
        send_frame(48'({$urandom(), $urandom()}), 1'b0);
      end
    end
  endtask

  // receiver side
  initial begin : drain_side
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (hold_req && !held) begin
        held       = 1'b1;
        stall_left = HoldCycles;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= !(recv_stall && $urandom_range(99) < idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [ByteW-1:0] sync_plan [NumPhases];
    logic [ByteW-1:0] type_plan [NumPhases];
    idle_mode_e       mode;
    sync_plan = '{8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00};
    type_plan = '{8'h18, 8'hFF, 8'h5A, 8'h00, 8'h00};
    sync_plan[4] = 8'($urandom_range(255));
    type_plan[4] = 8'($urandom_range(255));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero and full-scale readings, repeated sync, bad checksum
    send_frame(48'h0000_0000_0000, 1'b0);
    push_byte(sync_cfg);
    send_frame(48'hFFFF_FFFF_FFFF, 1'b0);
    send_frame(48'h0000_A55A_0000, 1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      mode = idle_mode_e'(p % 4);
      if (p > 0) begin
        settle();
        write_reg(REG_SYNC, sync_plan[p]);
        write_reg(REG_TYPE, type_plan[p]);
        cfg_we   <= 1'b0;
        sync_cfg = sync_plan[p];
        type_cfg = type_plan[p];
      end
      send_idle  = (mode == IDLE_SEND || mode == IDLE_BOTH);
      recv_stall = (mode == IDLE_RECV || mode == IDLE_BOTH);
      idle_pct   = (mode == IDLE_BOTH) ? 23 : 68;
      // long receiver hold-off while the sender keeps offering words
      if (p == 0) hold_req = 1'b1;
      random_traffic();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/sufp_pkg.sv
hdl/sufp_core.sv
hdl/sensor_uart_frame_parser.sv
dv/sufp_frame_checker.sv
dv/tb_sensor_uart_frame_parser.sv
